FILE: design/assert_macros.svh
// Assertion macros used by the frame store datapath.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: property does not hold");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: design/mdfs_pkg.sv
// Package for the monochrome display frame store: geometry, stream codes,
// controller states and the command and status structs. No dependencies.
`default_nettype none

package mdfs_pkg;

  localparam int COLUMNS    = 128;
  localparam int PAGES      = 8;
  localparam int ROWS       = PAGES * 8;
  localparam int DEPTH      = COLUMNS * PAGES;
  localparam int STREAM_LEN = COLUMNS + 3;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PAGE_W = $clog2(PAGES);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(STREAM_LEN);

  localparam int CFG_W  = 4;
  localparam int BYTE_W = 8;
  localparam int ITEM_W = 24;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Byte positions inside one page of the stream.
  localparam int POS_PAGE_CMD = 0;
  localparam int POS_COL_LOW  = 1;
  localparam int POS_COL_HIGH = 2;
  localparam int POS_DATA     = 3;

  localparam logic [2:0] KIND_PIXEL   = 3'd0;
  localparam logic [2:0] KIND_BYTE    = 3'd1;
  localparam logic [2:0] KIND_FILL    = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_REFRESH = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX_WR,
    S_FILL,
    S_STREAM
  } state_t;

  typedef struct packed {
    logic pix_read;
    logic pix_write;
    logic byte_write;
    logic fill_start;
    logic clear_start;
    logic sweep_write;
    logic stream_read;
    logic stream_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic sweep_last;
  } status_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [COL_W-1:0] col);
    store_addr = ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

FILE: design/mdfs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependencies.
`default_nettype none

module mdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/mdfs_ctrl.sv
// Controller state machine of the frame store: accepts items, sequences
// pixel updates, sweeps and stream reads. Depends on mdfs_pkg.
`default_nettype none

module mdfs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic [2:0]       kind,
  output logic                  s_tready,
  output mdfs_pkg::cmd_t        cmd,
  input  wire mdfs_pkg::status_t status
);

  mdfs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdfs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      mdfs_pkg::S_CLEAR, mdfs_pkg::S_FILL: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = mdfs_pkg::S_IDLE;
        end
      end
      mdfs_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (kind)
            mdfs_pkg::KIND_PIXEL: begin
              cmd.pix_read = 1'b1;
              state_next   = mdfs_pkg::S_PIX_WR;
            end
            mdfs_pkg::KIND_BYTE: begin
              cmd.byte_write = 1'b1;
            end
            mdfs_pkg::KIND_FILL: begin
              cmd.fill_start = 1'b1;
              state_next     = mdfs_pkg::S_FILL;
            end
            mdfs_pkg::KIND_CLEAR: begin
              cmd.clear_start = 1'b1;
              state_next      = mdfs_pkg::S_CLEAR;
            end
            mdfs_pkg::KIND_REFRESH: begin
              cmd.stream_read = 1'b1;
              state_next      = mdfs_pkg::S_STREAM;
            end
            default: begin
              // Unused kinds are consumed without effect.
            end
          endcase
        end
      end
      mdfs_pkg::S_PIX_WR: begin
        cmd.pix_write = 1'b1;
        state_next    = mdfs_pkg::S_IDLE;
      end
      mdfs_pkg::S_STREAM: begin
        if (status.out_free) begin
          cmd.stream_emit = 1'b1;
          state_next      = mdfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mdfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/mdfs_datapath.sv
// Datapath of the frame store: store RAM, sweep address counter, pixel
// update, stream position and output register. Depends on mdfs_pkg, mdfs_ram.
`default_nettype none
`include "assert_macros.svh"

module mdfs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mdfs_pkg::ITEM_W-1:0]   item_data,
  input  wire logic                          cfg_valid,
  input  wire logic [mdfs_pkg::CFG_W-1:0]    cfg_data,
  input  wire mdfs_pkg::cmd_t                cmd,
  output mdfs_pkg::status_t                  status,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mdfs_pkg::BYTE_W-1:0]        m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast
);

  localparam int AW = mdfs_pkg::ADDR_W;
  localparam int CW = mdfs_pkg::COL_W;
  localparam int PW = mdfs_pkg::PAGE_W;
  localparam int RW = mdfs_pkg::ROW_W;
  localparam int SW = mdfs_pkg::POS_W;

  logic [7:0] in_col, in_row, in_val;
  logic [CW-1:0] col_sat;
  logic [RW-1:0] row_sat;
  logic [PW-1:0] byte_page, fill_page;
  logic [AW-1:0] pix_in_addr, byte_addr, fill_addr;

  logic [mdfs_pkg::CFG_W-1:0] column_start_low;
  logic [AW-1:0] pix_addr;
  logic [2:0]    pix_bit;
  logic          pix_on;
  logic [7:0]    pix_mask, pix_byte;

  logic [AW-1:0] addr_cnt, sweep_end;
  logic [7:0]    sweep_val;

  logic [PW-1:0] stream_page;
  logic [SW-1:0] stream_pos;
  logic [AW-1:0] stream_addr;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  logic [7:0] emit_byte;
  logic       emit_cmd, emit_eof;

  assign in_col = item_data[7:0];
  assign in_row = item_data[15:8];
  assign in_val = item_data[23:16];

  assign col_sat = (in_col > 8'(mdfs_pkg::COLUMNS - 1)) ? CW'(mdfs_pkg::COLUMNS - 1)
                                                        : in_col[CW-1:0];
  assign row_sat = (in_row > 8'(mdfs_pkg::ROWS - 1)) ? RW'(mdfs_pkg::ROWS - 1)
                                                     : in_row[RW-1:0];
  assign byte_page = (in_row > 8'(mdfs_pkg::PAGES - 1)) ? PW'(mdfs_pkg::PAGES - 1)
                                                        : in_row[PW-1:0];
  assign fill_page = (in_row > 8'(mdfs_pkg::PAGES - 2)) ? PW'(mdfs_pkg::PAGES - 2)
                                                        : in_row[PW-1:0];

  assign pix_in_addr = mdfs_pkg::store_addr(PW'(row_sat >> 3), col_sat);
  assign byte_addr   = mdfs_pkg::store_addr(byte_page, col_sat);
  assign fill_addr   = mdfs_pkg::store_addr(fill_page, CW'(0));

  // Configuration register; writes must arrive only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_start_low <= '0;
    end else if (cfg_valid) begin
      column_start_low <= cfg_data;
    end
  end

  // Pixel operands are held for the write cycle after the read.
  always_ff @(posedge clk) begin
    if (cmd.pix_read) begin
      pix_addr <= pix_in_addr;
      pix_bit  <= row_sat[2:0];
      pix_on   <= (in_val != 8'd0);
    end
  end

  assign pix_mask = 8'd1 << pix_bit;
  assign pix_byte = pix_on ? (rd_data | pix_mask) : (rd_data & ~pix_mask);

  // Sweep counter shared by fill and clear; reset starts a full clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_cnt  <= '0;
      sweep_end <= AW'(mdfs_pkg::DEPTH - 1);
      sweep_val <= 8'd0;
    end else if (cmd.fill_start) begin
      addr_cnt  <= fill_addr;
      sweep_end <= fill_addr + AW'(2 * mdfs_pkg::COLUMNS - 1);
      sweep_val <= in_val;
    end else if (cmd.clear_start) begin
      addr_cnt  <= '0;
      sweep_end <= AW'(mdfs_pkg::DEPTH - 1);
      sweep_val <= 8'd0;
    end else if (cmd.sweep_write) begin
      addr_cnt <= addr_cnt + AW'(1);
    end
  end

  assign stream_addr = mdfs_pkg::store_addr(stream_page,
                                            CW'(stream_pos - SW'(mdfs_pkg::POS_DATA)));

  always_comb begin
    if (cmd.sweep_write) begin
      wr_addr = addr_cnt;
      wr_data = sweep_val;
    end else if (cmd.pix_write) begin
      wr_addr = pix_addr;
      wr_data = pix_byte;
    end else begin
      wr_addr = byte_addr;
      wr_data = in_val;
    end
  end

  assign wr_en   = cmd.sweep_write | cmd.pix_write | cmd.byte_write;
  assign rd_en   = cmd.pix_read | cmd.stream_read;
  assign rd_addr = cmd.stream_read ? stream_addr : pix_in_addr;

  mdfs_ram #(
    .WIDTH (8),
    .DEPTH (mdfs_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    emit_cmd = 1'b1;
    emit_eof = 1'b0;
    if (stream_pos == SW'(mdfs_pkg::POS_PAGE_CMD)) begin
      emit_byte = mdfs_pkg::CMD_PAGE_BASE + 8'(stream_page);
    end else if (stream_pos == SW'(mdfs_pkg::POS_COL_LOW)) begin
      emit_byte = 8'(column_start_low);
    end else if (stream_pos == SW'(mdfs_pkg::POS_COL_HIGH)) begin
      emit_byte = mdfs_pkg::CMD_COL_HIGH;
    end else begin
      emit_byte = rd_data;
      emit_cmd  = 1'b0;
      emit_eof  = (stream_page == PW'(mdfs_pkg::PAGES - 1)) &&
                  (stream_pos == SW'(mdfs_pkg::STREAM_LEN - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_page <= '0;
      stream_pos  <= '0;
    end else if (cmd.stream_emit) begin
      if (stream_pos == SW'(mdfs_pkg::STREAM_LEN - 1)) begin
        stream_pos  <= '0;
        stream_page <= (stream_page == PW'(mdfs_pkg::PAGES - 1)) ? '0
                                                                 : stream_page + PW'(1);
      end else begin
        stream_pos <= stream_pos + SW'(1);
      end
    end
  end

  // The output register lets the next item be accepted while a byte waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.stream_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stream_emit) begin
      m_tdata <= emit_byte;
      m_tuser <= emit_cmd;
      m_tlast <= emit_eof;
    end
  end

  assign status.out_free   = ~m_tvalid | m_tready;
  assign status.sweep_last = (addr_cnt == sweep_end);

  `ASSERT_HOLDS(a_emit_needs_slot, clk, rst, cmd.stream_emit |-> status.out_free)
  `ASSERT_HOLDS(a_one_writer, clk, rst, $onehot0({cmd.sweep_write, cmd.pix_write, cmd.byte_write}))
  `ASSERT_HOLDS(a_pos_in_range, clk, rst, stream_pos <= SW'(mdfs_pkg::STREAM_LEN - 1))
  `ASSERT_HOLDS(a_sweep_in_range, clk, rst, cmd.sweep_write |-> addr_cnt <= sweep_end)
  `ASSERT_HOLDS(a_pix_write_follows_read, clk, rst, cmd.pix_read |=> cmd.pix_write)

endmodule

`default_nettype wire

FILE: design/mono_display_frame_store_core.sv
// Monochrome 128x64 page-organized frame store with a panel refresh stream.
// Each refresh-step item yields one stream byte: per page, three command
// bytes (0xB0+page, the low column start nibble, 0x10) then 128 data bytes;
// tlast marks the last data byte of the last page. After reset the store is
// cleared by a pass over all of it during which no item is accepted. A byte
// write is stored in the cycle it is accepted, a pixel update reads then
// writes the store, and a refresh step reads the store and then waits for
// the previous byte to leave the output register. A two-page fill and a clear
// are paced by the single write port of the store RAM, one byte per cycle.
`default_nettype none

module mono_display_frame_store_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // column [7:0], row [15:8], value [23:16]
  input  wire logic [2:0]  s_tuser,   // kind [2:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,  // column_start_low
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // stream_byte [7:0]
  output logic             m_tuser,   // is_command [0]
  output logic             m_tlast    // end_of_frame
);

  mdfs_pkg::cmd_t    cmd;
  mdfs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  mdfs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item_data (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/mdfs_stream_checker.sv
// Checker for the monochrome display frame store: tracks the frame image, the
// refresh stream position and the column start register from the accepted
// items and register writes and compares every stream byte. Depends on mdfs_pkg.
`timescale 1ns / 100ps

module mdfs_stream_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [23:0] s_tdata,   // column [7:0], row [15:8], value [23:16]
  input  wire logic [2:0]  s_tuser,   // kind [2:0]
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [3:0]  cfg_data,  // column_start_low
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,   // stream_byte [7:0]
  input  wire logic        m_tuser,   // is_command [0]
  input  wire logic        m_tlast,   // end_of_frame
  output int               fail_count,
  output int               pending
);
  import mdfs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       eof;
  } panel_byte_t;

  logic [7:0]  frame_img [DEPTH];
  int          strm_page;
  int          strm_pos;
  logic [3:0]  col_start;
  panel_byte_t panel_bytes_due [$];
  int          errs = 0;

  // Applies one accepted item to the image and, for a refresh step, queues
  // the byte the panel stream must carry next.
  function automatic void apply_frame_op(input logic [2:0] kind, input logic [7:0] col,
                                         input logic [7:0] row, input logic [7:0] val);
    int          x;
    int          y;
    int          pg;
    int          i;
    panel_byte_t nb;
    x = (col > COLUMNS - 1) ? COLUMNS - 1 : int'(col);
    case (kind)
      KIND_PIXEL: begin
        y = (row > ROWS - 1) ? ROWS - 1 : int'(row);
        frame_img[(y / 8) * COLUMNS + x][y % 8] = (val != 8'h00);
      end
      KIND_BYTE: begin
        pg = (row > PAGES - 1) ? PAGES - 1 : int'(row);
        frame_img[pg * COLUMNS + x] = val;
      end
      KIND_FILL: begin
        pg = (row > PAGES - 2) ? PAGES - 2 : int'(row);
        for (i = 0; i < 2 * COLUMNS; i++) frame_img[pg * COLUMNS + i] = val;
      end
      KIND_CLEAR: begin
        for (i = 0; i < DEPTH; i++) frame_img[i] = 8'h00;
      end
      KIND_REFRESH: begin
        nb.cmd = 1'b1;
        nb.eof = 1'b0;
        if (strm_pos == POS_PAGE_CMD) begin
          nb.data = 8'(CMD_PAGE_BASE + strm_page);
        end else if (strm_pos == POS_COL_LOW) begin
          nb.data = {4'h0, col_start};
        end else if (strm_pos == POS_COL_HIGH) begin
          nb.data = CMD_COL_HIGH;
        end else begin
          nb.cmd  = 1'b0;
          nb.data = frame_img[strm_page * COLUMNS + strm_pos - POS_DATA];
          nb.eof  = (strm_page == PAGES - 1) && (strm_pos == STREAM_LEN - 1);
        end
        panel_bytes_due.push_back(nb);
        strm_pos++;
        if (strm_pos >= STREAM_LEN) begin
          strm_pos = 0;
          strm_page = (strm_page + 1) % PAGES;
        end
      end
      default: begin
        // Unused kinds leave everything as it is.
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    panel_byte_t want;
    int          i;
    if (rst) begin
      for (i = 0; i < DEPTH; i++) frame_img[i] = 8'h00;
      strm_page = 0;
      strm_pos  = 0;
      col_start = 4'h0;
      panel_bytes_due.delete();
    end else begin
      // The output side is checked first: a byte leaving now belongs to an
      // earlier item, never to one accepted at this edge.
      if (m_tvalid && m_tready) begin
        if (panel_bytes_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected stream item: expected none, got byte %h cmd %b eof %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = panel_bytes_due.pop_front();
          if (m_tdata !== want.data || m_tuser !== want.cmd || m_tlast !== want.eof) begin
            errs++;
            $display("%0t: mismatch: expected byte %h cmd %b eof %b, got byte %h cmd %b eof %b",
                     $time, want.data, want.cmd, want.eof, m_tdata, m_tuser, m_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) col_start = cfg_data;
      if (s_tvalid && s_tready)
        apply_frame_op(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
    end
    fail_count <= errs;
    pending    <= panel_bytes_due.size();
  end

endmodule

FILE: tb/tb_mono_display_frame_store_core.sv
// Top of the frame store testbench: clock, reset, item and register stimulus,
// random output stalls, watchdog and verdict. Depends on mdfs_pkg, the
// mono_display_frame_store_core RTL and mdfs_stream_checker.
`timescale 1ns / 100ps

module tb_mono_display_frame_store_core;
  import mdfs_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;
  // A clear gives no result, so it may still be
  // running after the last stream byte has been taken.
  localparam int SETTLE_CYCLES  = 1100;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int PHASE_ITEMS    = 360;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          steady_sender = 1'b0;

  mono_display_frame_store_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  mdfs_stream_checker stream_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_op(input logic [2:0] kind, input logic [7:0] col,
                         input logic [7:0] row, input logic [7:0] val);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {val, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_column_start(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The extra edge lets the checker's count include the item just taken.
  task automatic wait_stream_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    int          r;
    logic [2:0]  kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [7:0]  val;
    r   = $urandom_range(0, 99);
    col = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, COLUMNS - 1));
    row = 8'($urandom_range(0, 255));
    val = 8'($urandom_range(0, 255));
    if (r < 80) begin
      kind = KIND_REFRESH;
    end else if (r < 87) begin
      kind = KIND_PIXEL;
      if ($urandom_range(0, 7) != 0) row = 8'($urandom_range(0, ROWS - 1));
      if ($urandom_range(0, 2) == 0) val = 8'h00;
    end else if (r < 93) begin
      kind = KIND_BYTE;
      if ($urandom_range(0, 7) != 0) row = 8'($urandom_range(0, PAGES - 1));
    end else if (r < 95) begin
      kind = KIND_FILL;
      if ($urandom_range(0, 7) != 0) row = 8'($urandom_range(0, PAGES - 2));
    end else if (r < 96) begin
      kind = KIND_CLEAR;
    end else begin
      kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end
    send_op(kind, col, row, val);
  endtask

  // Output side: bursts of ready, some of them long, broken by random stalls.
  initial begin : panel_sink
    int run;
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mono_display_frame_store_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int         phase;
    int         n;
    logic [3:0] col_start;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_REFRESH;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_column_start(4'd2);

    // Saturation of column and row in pixel writes, of column and page in byte writes, of page in fills.
    send_op(KIND_PIXEL, 8'd0, 8'd0, 8'h01);
    send_op(KIND_PIXEL, 8'd255, 8'd255, 8'hFF);
    send_op(KIND_PIXEL, 8'd127, 8'd63, 8'h00);
    send_op(KIND_PIXEL, 8'd128, 8'd64, 8'h80);
    send_op(KIND_BYTE, 8'd0, 8'd0, 8'hFF);
    send_op(KIND_BYTE, 8'd255, 8'd255, 8'h80);
    send_op(KIND_BYTE, 8'd127, 8'd7, 8'h01);
    send_op(KIND_FILL, 8'd200, 8'd255, 8'hA5);
    send_op(KIND_FILL, 8'd0, 8'd0, 8'h5A);
    send_op(KIND_FILL, 8'd255, 8'd6, 8'h00);
    send_op(KIND_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF);
    send_op(KIND_UNUSED_MID, 8'h00, 8'h00, 8'h00);
    send_op(KIND_UNUSED_HI, 8'h3C, 8'h01, 8'hC3);
    // The three command bytes of page 0, then data.
    repeat (5) send_op(KIND_REFRESH, 8'h00, 8'h00, 8'h00);
    // A write ahead of the stream position shows up in the next data bytes.
    send_op(KIND_BYTE, 8'd3, 8'd0, 8'h77);
    repeat (2) send_op(KIND_REFRESH, 8'hFF, 8'hFF, 8'hFF);
    // Clearing keeps the stream position.
    send_op(KIND_CLEAR, 8'h55, 8'hAA, 8'h55);
    send_op(KIND_REFRESH, 8'h00, 8'h00, 8'h00);

    for (phase = 0; phase < 4; phase++) begin
      wait_stream_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (phase)
        0:       col_start = 4'd15;
        1:       col_start = 4'd0;
        2:       col_start = 4'($urandom_range(0, 15));
        default: col_start = 4'd2;
      endcase
      write_column_start(col_start);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) steady_sender = ($urandom_range(0, 3) == 0);
        send_random_op();
      end
    end

    wait_stream_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("mono_display_frame_store_core regression: pass");
    end else begin
      $display("mono_display_frame_store_core regression: fail");
    end
    $finish;
  end

endmodule
